// ===== hw/rtl/png_stored_rgb_encoder_unit_defines.svh =====
// Assertion helpers shared by the encoder RTL.
`ifndef PNG_STORED_RGB_ENCODER_UNIT_DEFINES_SVH
`define PNG_STORED_RGB_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PNGSE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("encoder check failed");

// Next-cycle implication, checked outside reset.
`define PNGSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("encoder check failed");

`endif

// ===== hw/rtl/pngse_pkg.sv =====
package pngse_pkg;

	localparam int unsigned BLOCK_PAYLOAD_LIMIT = 60000;

	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	// chunk kinds
	localparam logic [1:0] KIND_IHDR = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_TAIL = 2'd2;
	localparam logic [1:0] KIND_IEND = 2'd3;

	// register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// input commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	typedef struct packed {
		logic crc_en;
		logic crc_init;
		logic adler_en;
		logic adler_init;
	} chk_op_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] i);
		logic [7:0] b;
		case (i)
			3'd0: b = 8'h89;
			3'd1: b = 8'h50;
			3'd2: b = 8'h4E;
			3'd3: b = 8'h47;
			3'd4: b = 8'h0D;
			3'd5: b = 8'h0A;
			3'd6: b = 8'h1A;
			default: b = 8'h0A;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] type_byte(input logic [1:0] kind, input logic [1:0] i);
		logic [31:0] t;
		case (kind)
			KIND_IHDR: t = 32'h49484452;
			KIND_IEND: t = 32'h49454E44;
			default:   t = 32'h49444154;
		endcase
		return t[8*(3-i) +: 8];
	endfunction

endpackage

// ===== hw/rtl/pngse_chk.sv =====
module pngse_chk
	import pngse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  chk_op_t     op,
	input  logic [7:0]  data,
	output logic [31:0] crc,
	output logic [15:0] adler_lo,
	output logic [15:0] adler_hi
);

	logic [31:0] crc_q, crc_n;
	logic [15:0] lo_q, hi_q, lo_n, hi_n;
	logic [16:0] lo_sum, hi_sum;

	always_comb begin
		crc_n = (op.crc_init ? 32'hFFFFFFFF : crc_q) ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			crc_n = (crc_n >> 1) ^ (CRC_POLY & {32{crc_n[0]}});
		end
		lo_sum = {1'b0, lo_q} + {9'd0, data};
		lo_n   = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
		hi_sum = {1'b0, hi_q} + {1'b0, lo_n};
		hi_n   = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 32'hFFFFFFFF;
			lo_q  <= 16'd1;
			hi_q  <= 16'd0;
		end else begin
			if (op.crc_en) begin
				crc_q <= crc_n;
			end
			if (op.adler_init) begin
				lo_q <= 16'd1;
				hi_q <= 16'd0;
			end else if (op.adler_en) begin
				lo_q <= lo_n;
				hi_q <= hi_n;
			end
		end
	end

	assign crc      = crc_q;
	assign adler_lo = lo_q;
	assign adler_hi = hi_q;

endmodule

// ===== hw/rtl/png_stored_rgb_encoder_unit.sv =====
// PNG encoder for 24-bit RGB, uncompressed (stored deflate blocks).
// Input stream: s_tuser is the command (0 start frame, 1 pixel), s_tdata the
// pixel. Output stream: one PNG byte per beat on m_tdata, m_tlast on the
// final byte caused by an input beat, m_tuser on the final byte of the file.
// Config channel: cfg_index 0 writes width, 1 writes height; both are
// latched by the start command. Write only while the block is idle.
// A start runs a restoring divide (rows per block), then emits the
// 8-byte signature and the 25-byte IHDR chunk.
// A pixel emits its 3 bytes and then returns to idle; the first pixel
// of a row adds the filter byte, and the first row of a block is sized
// (rows, payload, length) and adds 13 or 15 bytes of IDAT opening.
// Block and frame ends add the chunk trailers (up to 37 bytes).
// One byte leaves per cycle while the receiver accepts, through the shared
// CRC/Adler unit; s_tready is low while a beat's bytes are being produced.
// A stalled receiver holds the output register and the byte-emitting states.
// Reset empties the output, drops any frame and restores width 320 and
// height 240; pixels are ignored until a valid start.
module png_stored_rgb_encoder_unit
	import pngse_pkg::*;
#(
	parameter int unsigned PAYLOAD_MAX = BLOCK_PAYLOAD_LIMIT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_rgb
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic        m_tlast,   // last_of_run
	output logic        m_tuser,   // end_of_file
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	`include "png_stored_rgb_encoder_unit_defines.svh"

	localparam logic [15:0] LIMIT = 16'(PAYLOAD_MAX);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_SIG  = 4'd2;
	localparam logic [3:0] ST_LEN  = 4'd3;
	localparam logic [3:0] ST_TYPE = 4'd4;
	localparam logic [3:0] ST_IHDR = 4'd5;
	localparam logic [3:0] ST_CRC  = 4'd6;
	localparam logic [3:0] ST_MUL  = 4'd7;
	localparam logic [3:0] ST_ZHDR = 4'd8;
	localparam logic [3:0] ST_BLK  = 4'd9;
	localparam logic [3:0] ST_FILT = 4'd10;
	localparam logic [3:0] ST_PIX  = 4'd11;
	localparam logic [3:0] ST_TAIL = 4'd12;

	logic [3:0]  state_q;
	logic [4:0]  idx_q;
	logic [1:0]  kind_q;
	logic [14:0] cfg_w_q, fw_q, col_q;
	logic [15:0] cfg_h_q, fh_q, row_q, rows_left_q, rpb_q, pay_q, len_q;
	logic [16:0] rem_q, row_len, trial;
	logic        first_q, active_q;
	logic [23:0] pix_q;
	logic        m_valid_q, m_last_q, m_eof_q;
	logic [7:0]  m_byte_q;

	logic        emit, adv, seg_last, row_end, size_ok, in_acc;
	logic [4:0]  seg_len;
	logic [7:0]  byte_val;
	logic [31:0] crc, crc_inv;
	logic [15:0] adler_lo, adler_hi, rows_rem, rows_min;
	logic [32:0] product;
	logic        last_val, eof_val;
	chk_op_t     op;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;

	assign row_len = 17'd1 + 17'd3 * {2'd0, cfg_w_q};
	assign size_ok = (cfg_w_q != 15'd0) && (cfg_h_q != 16'd0) && (row_len <= {1'b0, LIMIT});
	assign trial   = {rem_q[15:0], LIMIT[4'(5'd15 - idx_q)]};
	assign row_end = (col_q == fw_q - 15'd1);
	assign rows_rem = fh_q - row_q;
	assign rows_min = (rows_rem > rpb_q) ? rpb_q : rows_rem;
	assign product  = {17'd0, rows_left_q} * {16'd0, (17'd1 + 17'd3 * {2'd0, fw_q})};
	assign crc_inv  = ~crc;

	always_comb begin
		emit    = 1'b1;
		seg_len = 5'd1;
		unique case (state_q)
			ST_SIG:  seg_len = 5'd8;
			ST_LEN:  seg_len = 5'd4;
			ST_TYPE: seg_len = 5'd4;
			ST_IHDR: seg_len = 5'd13;
			ST_CRC:  seg_len = 5'd4;
			ST_ZHDR: seg_len = 5'd2;
			ST_BLK:  seg_len = 5'd5;
			ST_FILT: seg_len = 5'd1;
			ST_PIX:  seg_len = 5'd3;
			ST_TAIL: seg_len = 5'd9;
			default: emit = 1'b0;
		endcase
	end

	assign adv      = emit && (!m_valid_q || m_tready);
	assign seg_last = (idx_q == seg_len - 5'd1);

	always_comb begin
		byte_val = 8'h00;
		case (state_q)
			ST_SIG:  byte_val = sig_byte(idx_q[2:0]);
			ST_LEN:  byte_val = idx_q[1] ? (idx_q[0] ? len_q[7:0] : len_q[15:8]) : 8'h00;
			ST_TYPE: byte_val = type_byte(kind_q, idx_q[1:0]);
			ST_IHDR: begin
				case (idx_q)
					5'd2:    byte_val = {1'b0, fw_q[14:8]};
					5'd3:    byte_val = fw_q[7:0];
					5'd6:    byte_val = fh_q[15:8];
					5'd7:    byte_val = fh_q[7:0];
					5'd8:    byte_val = 8'h08;
					5'd9:    byte_val = 8'h02;
					default: byte_val = 8'h00;
				endcase
			end
			ST_CRC:  byte_val = crc_inv[8*(3-idx_q[1:0]) +: 8];
			ST_ZHDR: byte_val = idx_q[0] ? 8'h01 : 8'h78;
			ST_BLK: begin
				case (idx_q)
					5'd1:    byte_val = pay_q[7:0];
					5'd2:    byte_val = pay_q[15:8];
					5'd3:    byte_val = ~pay_q[7:0];
					5'd4:    byte_val = ~pay_q[15:8];
					default: byte_val = 8'h00;
				endcase
			end
			ST_PIX:  byte_val = pix_q[8*(2-idx_q[1:0]) +: 8];
			ST_TAIL: begin
				case (idx_q)
					5'd0:    byte_val = 8'h01;
					5'd3:    byte_val = 8'hFF;
					5'd4:    byte_val = 8'hFF;
					5'd5:    byte_val = adler_hi[15:8];
					5'd6:    byte_val = adler_hi[7:0];
					5'd7:    byte_val = adler_lo[15:8];
					5'd8:    byte_val = adler_lo[7:0];
					default: byte_val = 8'h00;
				endcase
			end
			default: byte_val = 8'h00;
		endcase
	end

	always_comb begin
		last_val = 1'b0;
		eof_val  = 1'b0;
		if (seg_last) begin
			if (state_q == ST_PIX) begin
				last_val = !(row_end && rows_left_q == 16'd1);
			end else if (state_q == ST_CRC) begin
				last_val = (kind_q == KIND_IHDR) || (kind_q == KIND_IEND)
					|| (kind_q == KIND_DATA && row_q < fh_q);
				eof_val  = (kind_q == KIND_IEND);
			end
		end
	end

	always_comb begin
		op.crc_en     = adv && (state_q == ST_TYPE || state_q == ST_IHDR || state_q == ST_ZHDR
			|| state_q == ST_BLK || state_q == ST_FILT || state_q == ST_PIX
			|| state_q == ST_TAIL);
		op.crc_init   = (state_q == ST_TYPE) && (idx_q == 5'd0);
		op.adler_en   = adv && (state_q == ST_FILT || state_q == ST_PIX);
		op.adler_init = in_acc && (s_tuser == CMD_START) && size_ok;
	end

	pngse_chk u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.data     (byte_val),
		.crc      (crc),
		.adler_lo (adler_lo),
		.adler_hi (adler_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= 15'd320;
			cfg_h_q <= 16'd240;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_WIDTH) begin
				cfg_w_q <= cfg_data[14:0];
			end else begin
				cfg_h_q <= cfg_data;
			end
		end
	end

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_byte_q <= byte_val;
			m_last_q <= last_val;
			m_eof_q  <= eof_val;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_byte_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= 5'd0;
			kind_q      <= KIND_IHDR;
			active_q    <= 1'b0;
			first_q     <= 1'b1;
			fw_q        <= 15'd0;
			fh_q        <= 16'd0;
			col_q       <= 15'd0;
			row_q       <= 16'd0;
			rows_left_q <= 16'd0;
			rpb_q       <= 16'd0;
			rem_q       <= 17'd0;
			pay_q       <= 16'd0;
			len_q       <= 16'd0;
			pix_q       <= 24'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= 5'd0;
					if (in_acc) begin
						if (s_tuser == CMD_START) begin
							active_q <= 1'b0;
							if (size_ok) begin
								active_q    <= 1'b1;
								fw_q        <= cfg_w_q;
								fh_q        <= cfg_h_q;
								col_q       <= 15'd0;
								row_q       <= 16'd0;
								rows_left_q <= 16'd0;
								first_q     <= 1'b1;
								rem_q       <= 17'd0;
								rpb_q       <= 16'd0;
								state_q     <= ST_DIV;
							end
						end else if (active_q) begin
							pix_q <= s_tdata;
							if (col_q != 15'd0) begin
								state_q <= ST_PIX;
							end else if (rows_left_q != 16'd0) begin
								state_q <= ST_FILT;
							end else begin
								state_q <= ST_MUL;
							end
						end
					end
				end
				ST_DIV: begin
					// one quotient bit per cycle
					if (trial >= {2'd0, fw_q} * 17'd3 + 17'd1) begin
						rem_q <= trial - ({2'd0, fw_q} * 17'd3 + 17'd1);
						rpb_q <= {rpb_q[14:0], 1'b1};
					end else begin
						rem_q <= trial;
						rpb_q <= {rpb_q[14:0], 1'b0};
					end
					idx_q <= idx_q + 5'd1;
					if (idx_q == 5'd15) begin
						idx_q   <= 5'd0;
						state_q <= ST_SIG;
					end
				end
				ST_MUL: begin
					idx_q <= idx_q + 5'd1;
					if (idx_q == 5'd0) begin
						rows_left_q <= rows_min;
					end else if (idx_q == 5'd1) begin
						pay_q <= product[15:0];
					end else begin
						len_q   <= pay_q + (first_q ? 16'd7 : 16'd5);
						kind_q  <= KIND_DATA;
						idx_q   <= 5'd0;
						state_q <= ST_LEN;
					end
				end
				default: begin
					if (adv) begin
						idx_q <= idx_q + 5'd1;
						if (seg_last) begin
							idx_q <= 5'd0;
							case (state_q)
								ST_SIG: begin
									len_q   <= 16'd13;
									kind_q  <= KIND_IHDR;
									state_q <= ST_LEN;
								end
								ST_LEN:  state_q <= ST_TYPE;
								ST_TYPE: begin
									case (kind_q)
										KIND_IHDR: state_q <= ST_IHDR;
										KIND_DATA: state_q <= first_q ? ST_ZHDR : ST_BLK;
										KIND_TAIL: state_q <= ST_TAIL;
										default:   state_q <= ST_CRC;
									endcase
								end
								ST_IHDR: state_q <= ST_CRC;
								ST_ZHDR: state_q <= ST_BLK;
								ST_BLK: begin
									first_q <= 1'b0;
									state_q <= ST_FILT;
								end
								ST_FILT: state_q <= ST_PIX;
								ST_PIX: begin
									state_q <= ST_IDLE;
									col_q   <= col_q + 15'd1;
									if (row_end) begin
										col_q       <= 15'd0;
										row_q       <= row_q + 16'd1;
										rows_left_q <= rows_left_q - 16'd1;
										if (rows_left_q == 16'd1) begin
											state_q <= ST_CRC;
										end
									end
								end
								ST_TAIL: state_q <= ST_CRC;
								default: begin
									// chunk trailer done: pick what follows
									state_q <= ST_IDLE;
									if (kind_q == KIND_DATA && row_q >= fh_q) begin
										len_q   <= 16'd9;
										kind_q  <= KIND_TAIL;
										state_q <= ST_LEN;
									end else if (kind_q == KIND_TAIL) begin
										len_q   <= 16'd0;
										kind_q  <= KIND_IEND;
										state_q <= ST_LEN;
									end else if (kind_q == KIND_IEND) begin
										active_q <= 1'b0;
									end
								end
							endcase
						end
					end
				end
			endcase
		end
	end

	`PNGSE_ASSERT_IMPL(a_eof_is_last, m_tvalid && m_tuser, m_tlast)
	`PNGSE_ASSERT_IMPL(a_busy_not_ready, state_q != ST_IDLE, !s_tready)
	`PNGSE_ASSERT_IMPL(a_rows_left_bound, active_q, rows_left_q <= rpb_q)
	`PNGSE_ASSERT_NEXT(a_start_runs_div, in_acc && s_tuser == CMD_START && size_ok,
		state_q == ST_DIV && active_q)

endmodule

// ===== tb/png_stored_rgb_encoder_unit_tb.sv =====
module png_stored_rgb_encoder_unit_tb;
	import pngse_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MODE_PLAIN = 0;
	localparam int MODE_CRC   = 1;
	localparam int MODE_BOTH  = 3;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_ITEMS = 290;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       eof;
	} png_byte_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // pixel_rgb
	logic        s_tuser;   // command
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // out_byte
	logic        m_tlast;   // last_of_run
	logic        m_tuser;   // end_of_file
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	png_stored_rgb_encoder_unit i_dut (.*);

	// file bytes still owed by the encoder
	png_byte_t png_bytes_q[$];

	int errors;
	int idle_pct;
	int stall_pct;
	int hold_cycles;
	int quiet_cycles;
	int items_sent;

	// encoder shadow state
	logic [14:0] reg_width;
	logic [15:0] reg_height;
	logic [31:0] crc_acc;
	int unsigned adler_a, adler_b;
	int unsigned col_idx, row_idx, rows_left, rows_blk, frm_w, frm_h;
	bit first_blk, frame_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic emit(input logic [7:0] b, input int mode);
		png_bytes_q.push_back('{data: b, last: 1'b0, eof: 1'b0});
		if (mode & MODE_CRC) begin
			crc_acc ^= {24'd0, b};
			for (int k = 0; k < 8; k++)
				crc_acc = (crc_acc >> 1) ^ (crc_acc[0] ? CRC_POLY : 32'd0);
		end
		if (mode & 2) begin
			adler_a += b;
			if (adler_a >= ADLER_MOD) adler_a -= ADLER_MOD;
			adler_b += adler_a;
			if (adler_b >= ADLER_MOD) adler_b -= ADLER_MOD;
		end
	endtask

	task automatic emit32(input logic [31:0] v, input int mode);
		for (int i = 3; i >= 0; i--)
			emit(v[8*i +: 8], mode);
	endtask

	task automatic open_chunk(input logic [31:0] len, input logic [1:0] kind);
		emit32(len, MODE_PLAIN);
		crc_acc = '1;
		for (int i = 0; i < 4; i++)
			emit(type_byte(kind, i[1:0]), MODE_CRC);
	endtask

	task automatic close_chunk();
		emit32(~crc_acc, MODE_PLAIN);
	endtask

	task automatic predict_file_bytes(input logic cmd, input logic [23:0] rgb);
		int unsigned row_len, rows, payload;
		int n0;
		n0 = png_bytes_q.size();
		if (cmd == CMD_START) begin
			frame_on = 0;
			row_len = 1 + 3 * reg_width;
			if (reg_width == 0 || reg_height == 0 || row_len > BLOCK_PAYLOAD_LIMIT)
				return;
			frm_w = reg_width;
			frm_h = reg_height;
			rows_blk = BLOCK_PAYLOAD_LIMIT / row_len;
			rows_left = 0;
			col_idx = 0;
			row_idx = 0;
			first_blk = 1;
			adler_a = 1;
			adler_b = 0;
			frame_on = 1;
			for (int i = 0; i < 8; i++)
				emit(sig_byte(i[2:0]), MODE_PLAIN);
			open_chunk(13, KIND_IHDR);
			emit32(frm_w, MODE_CRC);
			emit32(frm_h, MODE_CRC);
			emit(8'd8, MODE_CRC);
			emit(8'd2, MODE_CRC);
			repeat (3) emit(8'd0, MODE_CRC);
			close_chunk();
		end else begin
			if (!frame_on)
				return;
			row_len = 1 + 3 * frm_w;
			if (col_idx == 0) begin
				if (rows_left == 0) begin
					rows = frm_h - row_idx;
					if (rows > rows_blk) rows = rows_blk;
					rows_left = rows;
					payload = rows * row_len;
					open_chunk(payload + 5 + (first_blk ? 2 : 0), KIND_DATA);
					if (first_blk) begin
						emit(8'h78, MODE_CRC);
						emit(8'h01, MODE_CRC);
					end
					first_blk = 0;
					emit(8'h00, MODE_CRC);
					emit(payload[7:0], MODE_CRC);
					emit(payload[15:8], MODE_CRC);
					emit(~payload[7:0], MODE_CRC);
					emit(~payload[15:8], MODE_CRC);
				end
				emit(8'h00, MODE_BOTH);
			end
			emit(rgb[23:16], MODE_BOTH);
			emit(rgb[15:8], MODE_BOTH);
			emit(rgb[7:0], MODE_BOTH);
			col_idx++;
			if (col_idx >= frm_w) begin
				col_idx = 0;
				row_idx++;
				rows_left--;
				if (rows_left == 0) close_chunk();
				if (row_idx >= frm_h) begin
					open_chunk(9, KIND_TAIL);
					emit(8'h01, MODE_CRC);
					emit(8'h00, MODE_CRC);
					emit(8'h00, MODE_CRC);
					emit(8'hFF, MODE_CRC);
					emit(8'hFF, MODE_CRC);
					emit32({adler_b[15:0], adler_a[15:0]}, MODE_CRC);
					close_chunk();
					open_chunk(0, KIND_IEND);
					close_chunk();
					png_bytes_q[$].eof = 1'b1;
					frame_on = 0;
				end
			end
		end
		if (png_bytes_q.size() > n0)
			png_bytes_q[$].last = 1'b1;
	endtask

	// hold valid across back-to-back beats; drop it only during gaps
	task automatic send_beat(input logic cmd, input logic [23:0] rgb);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= rgb;
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_START || frame_on)
			items_sent++;
		predict_file_bytes(cmd, rgb);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (png_bytes_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_WIDTH) reg_width = val[14:0];
		else reg_height = val;
		@(posedge clk);
	endtask

	task automatic set_size(input logic [15:0] w, input logic [15:0] h);
		wait_idle();
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
	endtask

	task automatic send_pixels(input int count);
		for (int i = 0; i < count; i++)
			send_beat(CMD_PIXEL, 24'($urandom));
	endtask

	task automatic test_pixels_while_idle();
		send_beat(CMD_PIXEL, 24'hFFFFFF);
		send_beat(CMD_PIXEL, 24'h000000);
	endtask

	task automatic test_refused_sizes();
		set_size(16'd0, 16'd3);
		send_beat(CMD_START, 24'h0);
		set_size(16'd20000, 16'd3);
		send_beat(CMD_START, 24'h0);
		set_size(16'hFFFF, 16'd3);
		send_beat(CMD_START, 24'h0);
		set_size(16'd2, 16'd0);
		send_beat(CMD_START, 24'h0);
		send_beat(CMD_PIXEL, 24'h123456);
	endtask

	task automatic test_reset_size_and_abandon();
		// reset size 320x240, left unfinished
		send_beat(CMD_START, 24'h0);
		send_beat(CMD_PIXEL, 24'hFFFFFF);
		send_beat(CMD_PIXEL, 24'h000000);
		set_size(16'd19999, 16'hFFFF);
		send_beat(CMD_START, 24'h0);
		send_beat(CMD_PIXEL, 24'hA5A5A5);
		send_beat(CMD_START, 24'h0);
	endtask

	task automatic test_tiny_frames();
		set_size(16'd1, 16'd1);
		send_beat(CMD_START, 24'h0);
		send_beat(CMD_PIXEL, 24'hFFFFFF);
		send_beat(CMD_PIXEL, 24'h5A5A5A);
		set_size(16'd2, 16'd2);
		send_beat(CMD_START, 24'h0);
		send_pixels(4);
	endtask

	task automatic test_random_frames();
		int w, h, n, target;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			case ((items_sent - target + RANDOM_ITEMS) * 4 / RANDOM_ITEMS)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 71; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 71; end
				default: begin idle_pct = 27; stall_pct = 27; end
			endcase
			if ($urandom_range(9) == 0) begin
				w = $urandom_range(40, 25);
				h = $urandom_range(4, 2);
			end else begin
				w = $urandom_range(8, 1);
				h = $urandom_range(5, 1);
			end
			set_size(16'(w), 16'(h));
			send_beat(CMD_START, 24'($urandom));
			n = w * h;
			if ($urandom_range(9) == 0) n = $urandom_range(n);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(15))
					0: send_beat(CMD_PIXEL, 24'hFFFFFF);
					1: send_beat(CMD_PIXEL, 24'h000000);
					default: send_beat(CMD_PIXEL, 24'($urandom));
				endcase
			end
			if ($urandom_range(7) == 0) send_beat(CMD_PIXEL, 24'($urandom));
			if ($urandom_range(11) == 0) send_beat(CMD_START, 24'($urandom));
		end
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		set_size(16'd6, 16'd6);
		hold_cycles = 400;
		send_beat(CMD_START, 24'h0);
		send_pixels(36);
	endtask

	// result side
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (png_bytes_q.size() == 0) begin
					report("unexpected byte", m_tdata, 0);
				end else begin
					png_byte_t e;
					e = png_bytes_q.pop_front();
					if (m_tdata !== e.data) report("out_byte", m_tdata, e.data);
					if (m_tlast !== e.last) report("last_of_run", m_tlast, e.last);
					if (m_tuser !== e.eof) report("end_of_file", m_tuser, e.eof);
				end
			end
		end
	end

	initial begin
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		items_sent = 0;
		reg_width = 15'd320;
		reg_height = 16'd240;
		crc_acc = '1;
		adler_a = 1;
		adler_b = 0;
		col_idx = 0;
		row_idx = 0;
		rows_left = 0;
		rows_blk = 0;
		frm_w = 0;
		frm_h = 0;
		first_blk = 1;
		frame_on = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_START;
		cfg_valid = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pixels_while_idle();
		test_reset_size_and_abandon();
		test_refused_sizes();
		test_tiny_frames();
		test_backpressure();
		test_random_frames();

		stall_pct = 0;
		wait_idle();
		if (errors == 0 && png_bytes_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pngse_pkg.sv
hw/rtl/pngse_chk.sv
hw/rtl/png_stored_rgb_encoder_unit.sv
tb/png_stored_rgb_encoder_unit_tb.sv
